// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the find/replace RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SFR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SFR_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, register codes and helper functions for the stream find/replace.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CAP_W       = 13;
    localparam int CAP_RESET   = 4096;
    localparam int MAX_RESULTS = 8;
    localparam int RESN_W      = 4;
    localparam int COUNT_W     = 12;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACEMENT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REP_LEN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY    = 3'd4;

    // longest proper border of each pattern prefix
    typedef logic [7:0][3:0] t_fail;

    typedef struct packed {
        logic [63:0] pattern;
        logic [63:0] replacement;
        logic [3:0]  pat_len;
        logic [3:0]  rep_len;
        t_fail       fail;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic [7:0]         out_char;
        logic               char_valid;
        logic               end_of_text;
        logic [COUNT_W-1:0] output_count;
        logic               truncated;
    } t_result;

    function automatic logic [7:0] get_byte(input logic [63:0] word, input logic [2:0] idx);
        return word[{idx, 3'b000} +: 8];
    endfunction

    // Failure table: entry i is the longest proper prefix of the pattern that
    // is also a suffix of bytes 0..i.
    function automatic t_fail build_failure(input logic [63:0] pat);
        t_fail      f;
        logic       ok;
        logic [3:0] best;
        for (int i = 0; i < 8; i++) begin
            best = 4'd0;
            for (int k = 1; k <= i; k++) begin
                ok = 1'b1;
                for (int j = 0; j < k; j++) begin
                    if (pat[8*j +: 8] != pat[8*(i-k+1+j) +: 8]) begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    best = 4'(k);
                end
            end
            f[i] = best;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell
// One held-character slot of the match chain: load a new byte or take the
// byte of the right-hand neighbor when the chain drains toward slot zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell
    import sfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire logic [7:0] i_next_char,
    input  wire logic [7:0] i_load_char,
    output logic [7:0]      o_char
);

    logic [7:0] r_char;
    logic [7:0] n_char;

    always_comb begin
        n_char = r_char;
        if (i_ctl.shift) begin
            n_char = i_next_char;
        end else if (i_ctl.load) begin
            n_char = i_load_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

`default_nettype wire

// ===== rtl/sfr_core.sv =====
// ----------------------------------------------------------------------------
// sfr_core
// Match sequencer: tracks the partial match over a chain of held-character
// cells, falls back through the failure table and emits one byte per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfr_core
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int CW              = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic [CW-1:0] i_limit,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_fin,
    input  wire logic          i_out_free,
    output logic               o_push,
    output t_result            o_res
);

    localparam int MLW = $clog2(MAX_PATTERN + 1);
    localparam int RW  = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HELD = 3'd2;
    localparam logic [2:0] S_REPL = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]        r_state,  n_state;
    logic [7:0]        r_c,      n_c;
    logic              r_fin,    n_fin;
    logic [MLW-1:0]    r_ml,     n_ml;
    logic [MLW-1:0]    r_hcnt,   n_hcnt;
    logic              r_flush,  n_flush;
    logic [RW-1:0]     r_ridx,   n_ridx;
    logic [CW-1:0]     r_count,  n_count;
    logic              r_full,   n_full;
    logic [RESN_W-1:0] r_resn,   n_resn;
    t_result           r_pend,   n_pend;
    logic              r_pend_v, n_pend_v;

    logic [7:0] held_char [MAX_PATTERN];
    logic       held_shift;
    logic       char_load;

    logic [3:0] ml4;
    logic [7:0] pat_at_ml;
    logic [3:0] fail_at;
    logic       fallback;
    logic       match;
    logic [3:0] hold_n;
    logic       emit_req;
    logic [7:0] emit_ch;
    logic       emit_go;

    // held-character chain
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        t_cell_ctl  ctl;
        logic [7:0] next_char;

        assign ctl.shift = held_shift;
        assign ctl.load  = char_load && (r_ml == MLW'(g));

        if (g == MAX_PATTERN - 1) begin : g_tail
            assign next_char = 8'h00;
        end else begin : g_body
            assign next_char = held_char[g+1];
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_next_char (next_char),
            .i_load_char (r_c),
            .o_char      (held_char[g])
        );
    end

    assign ml4       = 4'(r_ml);
    assign pat_at_ml = get_byte(i_cfg.pattern, ml4[2:0]);
    assign fail_at   = i_cfg.fail[ml4[2:0] - 3'd1];

    always_comb begin
        if (i_cfg.pat_len == 4'd0) begin
            fallback = (r_ml != '0);
            hold_n   = ml4;
        end else begin
            fallback = (r_ml != '0) && ((ml4 >= i_cfg.pat_len) || (pat_at_ml != r_c));
            hold_n   = ml4 - fail_at;
        end
    end

    assign match = (i_cfg.pat_len != 4'd0) && (ml4 < i_cfg.pat_len) && (pat_at_ml == r_c);

    // an emit may need to move the pending result into the output register
    assign emit_go   = !r_pend_v || i_out_free;
    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_fin      = r_fin;
        n_ml       = r_ml;
        n_hcnt     = r_hcnt;
        n_flush    = r_flush;
        n_ridx     = r_ridx;
        n_count    = r_count;
        n_full     = r_full;
        n_resn     = r_resn;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        emit_req   = 1'b0;
        emit_ch    = 8'h00;
        held_shift = 1'b0;
        char_load  = 1'b0;
        o_push     = 1'b0;
        o_res      = r_pend;

        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_c     = i_char;
                    n_fin   = i_fin;
                    n_resn  = '0;
                    n_flush = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (fallback) begin
                    n_hcnt  = MLW'(hold_n);
                    n_state = S_HELD;
                end else if (match) begin
                    char_load = 1'b1;
                    if (ml4 + 4'd1 == i_cfg.pat_len) begin
                        n_ml    = '0;
                        n_ridx  = '0;
                        n_state = (i_cfg.rep_len != 4'd0) ? S_REPL : S_END;
                    end else begin
                        n_ml    = MLW'(r_ml + 1'b1);
                        n_state = S_END;
                    end
                end else begin
                    emit_req = 1'b1;
                    emit_ch  = r_c;
                    if (emit_go) begin
                        n_state = S_END;
                    end
                end
            end
            S_HELD: begin
                emit_req = 1'b1;
                emit_ch  = held_char[0];
                if (emit_go) begin
                    held_shift = 1'b1;
                    n_ml       = MLW'(r_ml - 1'b1);
                    n_hcnt     = MLW'(r_hcnt - 1'b1);
                    if (r_hcnt == MLW'(1)) begin
                        n_state = r_flush ? S_END : S_SCAN;
                    end
                end
            end
            S_REPL: begin
                emit_req = 1'b1;
                emit_ch  = get_byte(i_cfg.replacement, 3'(r_ridx));
                if (emit_go) begin
                    n_ridx = RW'(r_ridx + 1'b1);
                    if (4'(r_ridx) == i_cfg.rep_len - 4'd1) begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                if (r_fin && (r_ml != '0)) begin
                    // flush whatever is still held at end of string
                    n_hcnt  = r_ml;
                    n_flush = 1'b1;
                    n_state = S_HELD;
                end else if (r_fin) begin
                    o_push = i_out_free;
                    if (r_pend_v) begin
                        o_res = r_pend;
                    end else begin
                        o_res.out_char   = 8'h00;
                        o_res.char_valid = 1'b0;
                    end
                    o_res.end_of_text  = 1'b1;
                    o_res.output_count = COUNT_W'(r_count);
                    o_res.truncated    = r_full;
                    if (i_out_free) begin
                        n_count  = '0;
                        n_full   = 1'b0;
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_push   = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one emitted byte: count it, or mark the string full and drop it
        if (emit_req && emit_go && !r_full) begin
            if (r_count < i_limit) begin
                n_count = CW'(r_count + 1'b1);
                if (r_resn < RESN_W'(MAX_RESULTS)) begin
                    o_push              = r_pend_v;
                    o_res               = r_pend;
                    n_pend.out_char     = emit_ch;
                    n_pend.char_valid   = 1'b1;
                    n_pend.end_of_text  = 1'b0;
                    n_pend.output_count = COUNT_W'(n_count);
                    n_pend.truncated    = 1'b0;
                    n_pend_v            = 1'b1;
                    n_resn              = RESN_W'(r_resn + 1'b1);
                end
            end else begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_ml     <= '0;
            r_hcnt   <= '0;
            r_flush  <= 1'b0;
            r_ridx   <= '0;
            r_count  <= '0;
            r_full   <= 1'b0;
            r_resn   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_ml     <= n_ml;
            r_hcnt   <= n_hcnt;
            r_flush  <= n_flush;
            r_ridx   <= n_ridx;
            r_count  <= n_count;
            r_full   <= n_full;
            r_resn   <= n_resn;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_pend <= n_pend;
    end

    `SFR_ASSERT(a_resn_cap, i_clk, i_rst_n, r_resn <= RESN_W'(MAX_RESULTS), "too many results in one transaction")
    `SFR_ASSERT(a_idle_drained, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pend_v, "pending result left behind at idle")
    `SFR_ASSERT(a_held_work, i_clk, i_rst_n, (r_state == S_HELD) |-> (r_hcnt != '0 && r_ml >= r_hcnt), "held drain count out of range")
    `SFR_ASSERT(a_full_at_limit, i_clk, i_rst_n, $rose(r_full) |-> $past(r_count >= i_limit), "full flag set below the limit")
    `SFR_NEVER(a_no_overrun, i_clk, i_rst_n, o_push && !i_out_free, "result pushed into a busy output register")

endmodule

`default_nettype wire

// ===== rtl/stream_find_replace.sv =====
// Flow: a character is taken only while the sequencer is idle; before the next one it
// releases any held bytes, walks its fallback steps and emits any replacement bytes.
// A final character that still holds bytes flushes them; a busy output stalls the sequencer.
// Reset: synchronous, active low; restores register defaults, clears match state.
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming replace-all of a configured pattern with a configured replacement,
// with output capacity limit and a per-string emitted count.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int MAX_OUTPUT      = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [63:0]           i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [7:0] text_char
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tlast,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [7:0] out_char, [19:8] output_count, [20] truncated, [23:21] zero
    output logic [23:0]                o_m_tdata,
    // [0] char_valid
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);

    localparam int CW = $clog2(MAX_OUTPUT);
    localparam int CAP_EFF = (MAX_OUTPUT < CAP_RESET) ? MAX_OUTPUT : CAP_RESET;
    localparam logic [CW-1:0] LIMIT_RESET = CW'(CAP_EFF - 1);
    localparam logic [CW-1:0] LIMIT_MAX   = CW'(MAX_OUTPUT - 1);

    t_cfg          r_cfg,   n_cfg;
    logic [CW-1:0] r_limit, n_limit;
    t_result       r_out;
    logic          r_out_v;

    logic          out_free;
    logic          push;
    t_result       res;
    logic [CAP_W-1:0] cap;

    assign cap = i_cfg_data[CAP_W-1:0];

    always_comb begin
        n_cfg   = r_cfg;
        n_limit = r_limit;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PATTERN: begin
                    n_cfg.pattern = i_cfg_data;
                    n_cfg.fail    = build_failure(i_cfg_data);
                end
                CFG_PAT_LEN: begin
                    n_cfg.pat_len = (i_cfg_data[3:0] > 4'(MAX_PATTERN)) ?
                                    4'(MAX_PATTERN) : i_cfg_data[3:0];
                end
                CFG_REPLACEMENT: begin
                    n_cfg.replacement = i_cfg_data;
                end
                CFG_REP_LEN: begin
                    n_cfg.rep_len = (i_cfg_data[3:0] > 4'(MAX_REPLACEMENT)) ?
                                    4'(MAX_REPLACEMENT) : i_cfg_data[3:0];
                end
                CFG_CAPACITY: begin
                    // zero acts as one, anything past the buffer is clamped
                    if (cap == '0) begin
                        n_limit = '0;
                    end else if (17'(cap) > 17'(MAX_OUTPUT)) begin
                        n_limit = LIMIT_MAX;
                    end else begin
                        n_limit = CW'(cap - 1'b1);
                    end
                end
                default: begin
                    n_limit = r_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern     <= '0;
            r_cfg.replacement <= '0;
            r_cfg.pat_len     <= '0;
            r_cfg.rep_len     <= '0;
            r_cfg.fail        <= build_failure(64'd0);
            r_limit           <= LIMIT_RESET;
        end else begin
            r_cfg   <= n_cfg;
            r_limit <= n_limit;
        end
    end

    sfr_core #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .CW              (CW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_limit    (r_limit),
        .i_s_valid  (i_s_tvalid),
        .o_s_ready  (o_s_tready),
        .i_char     (i_s_tdata),
        .i_fin      (i_s_tlast),
        .i_out_free (out_free),
        .o_push     (push),
        .o_res      (res)
    );

    // output register: hold the result until the sink takes the transaction
    assign out_free = !r_out_v || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'b000, r_out.truncated, r_out.output_count, r_out.out_char};
    assign o_m_tuser  = r_out.char_valid;
    assign o_m_tlast  = r_out.end_of_text;

endmodule

`default_nettype wire

// ===== sim/stream_find_replace_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_checker
// Watches the register port and both streams of the find/replace block.
// It keeps its own replace-all model and its own copy of the registers. It
// compares every output transaction, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
module stream_find_replace_checker
    import sfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [63:0]           i_cfg_data,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // [7:0] text_char
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tlast,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [7:0] out_char, [19:8] output_count, [20] truncated, [23:21] zero
    input  wire logic [23:0]           i_m_tdata,
    // [0] char_valid
    input  wire logic                  i_m_tuser,
    input  wire logic                  i_m_tlast,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int OUT_MAX = 4096;
    localparam int PAT_MAX = 8;
    localparam int REP_MAX = 8;

    logic [63:0]      cfg_pat;
    logic [3:0]       cfg_plen;
    logic [63:0]      cfg_rep;
    logic [3:0]       cfg_rlen;
    logic [CAP_W-1:0] cfg_cap;
    t_fail            borders;

    logic [7:0]       held [8];
    int               held_n;
    int               sent_n;
    bit               capped;

    t_result          step_res [MAX_RESULTS];
    int               step_n;
    t_result          expected_out [$];
    int               mismatches = 0;

    assign o_mismatches = mismatches;

    // longest proper border of every pattern prefix, built incrementally
    function automatic t_fail kmp_borders(input logic [63:0] pat);
        t_fail t;
        int    k;
        t = '0;
        k = 0;
        for (int i = 1; i < 8; i++) begin
            while (k > 0 && pat[8*i +: 8] != pat[8*k +: 8]) begin
                k = t[k-1];
            end
            if (pat[8*i +: 8] == pat[8*k +: 8]) begin
                k++;
            end
            t[i] = k[3:0];
        end
        return t;
    endfunction

    function automatic logic [7:0] pattern_at(input int idx);
        return cfg_pat[8*idx +: 8];
    endfunction

    function automatic int emit_limit();
        int cap;
        cap = cfg_cap;
        if (cap == 0) begin
            cap = 1;
        end
        if (cap > OUT_MAX) begin
            cap = OUT_MAX;
        end
        return cap - 1;
    endfunction

    task automatic push_result(input logic [7:0] ch, input logic valid);
        t_result r;
        if (step_n < MAX_RESULTS) begin
            r.out_char     = ch;
            r.char_valid   = valid;
            r.end_of_text  = 1'b0;
            r.output_count = sent_n[COUNT_W-1:0];
            r.truncated    = capped;
            step_res[step_n] = r;
            step_n++;
        end
    endtask

    // refuse the byte and raise the flag once the string is full
    task automatic emit_char(input logic [7:0] ch);
        if (!capped) begin
            if (sent_n < emit_limit()) begin
                sent_n++;
                push_result(ch, 1'b1);
            end else begin
                capped = 1'b1;
            end
        end
    endtask

    task automatic release_held(input int cnt);
        int n;
        n = (cnt > held_n) ? held_n : cnt;
        for (int i = 0; i < n; i++) begin
            emit_char(held[i]);
        end
        for (int i = 0; i + n < 8; i++) begin
            held[i] = held[i+n];
        end
        held_n -= n;
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        int      plen;
        int      rlen;
        t_result tail;
        t_result want;
        if (!i_rst_n) begin
            cfg_pat  = '0;
            cfg_plen = '0;
            cfg_rep  = '0;
            cfg_rlen = '0;
            cfg_cap  = CAP_W'(CAP_RESET);
            borders  = kmp_borders('0);
            held_n   = 0;
            sent_n   = 0;
            capped   = 1'b0;
            expected_out.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PATTERN: begin
                        cfg_pat = i_cfg_data;
                        borders = kmp_borders(i_cfg_data);
                    end
                    CFG_PAT_LEN:     cfg_plen = i_cfg_data[3:0];
                    CFG_REPLACEMENT: cfg_rep  = i_cfg_data;
                    CFG_REP_LEN:     cfg_rlen = i_cfg_data[3:0];
                    CFG_CAPACITY:    cfg_cap  = i_cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                plen   = (cfg_plen > PAT_MAX) ? PAT_MAX : cfg_plen;
                rlen   = (cfg_rlen > REP_MAX) ? REP_MAX : cfg_rlen;
                step_n = 0;
                if (plen == 0) begin
                    release_held(held_n);
                    emit_char(i_s_tdata);
                end else begin
                    // fall back along the border chain until the byte can extend the match
                    while (held_n > 0 &&
                           (held_n >= plen || pattern_at(held_n) != i_s_tdata)) begin
                        release_held(held_n - borders[held_n-1]);
                    end
                    if (held_n < plen && pattern_at(held_n) == i_s_tdata) begin
                        held[held_n] = i_s_tdata;
                        held_n++;
                        if (held_n == plen) begin
                            for (int i = 0; i < rlen; i++) begin
                                emit_char(cfg_rep[8*i +: 8]);
                            end
                            held_n = 0;
                        end
                    end else begin
                        emit_char(i_s_tdata);
                    end
                end
                if (i_s_tlast) begin
                    // flush, then stamp the string totals on the last result
                    release_held(held_n);
                    if (step_n == 0) begin
                        push_result(8'h00, 1'b0);
                    end
                    tail              = step_res[step_n-1];
                    tail.end_of_text  = 1'b1;
                    tail.output_count = sent_n[COUNT_W-1:0];
                    tail.truncated    = capped;
                    step_res[step_n-1] = tail;
                    held_n = 0;
                    sent_n = 0;
                    capped = 1'b0;
                end
                for (int i = 0; i < step_n; i++) begin
                    expected_out.push_back(step_res[i]);
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                if (expected_out.size() == 0) begin
                    $error("output transaction with nothing expected: tdata %h tuser %b tlast %b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    compare_field("out_char", 12'(want.out_char), 12'(i_m_tdata[7:0]));
                    compare_field("char_valid", 12'(want.char_valid), 12'(i_m_tuser));
                    compare_field("end_of_text", 12'(want.end_of_text), 12'(i_m_tlast));
                    compare_field("output_count", want.output_count, i_m_tdata[19:8]);
                    compare_field("truncated", 12'(want.truncated), 12'(i_m_tdata[20]));
                end
            end
        end
        o_pending <= expected_out.size();
    end

endmodule

// ===== sim/stream_find_replace_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_tb
// Drives text strings into the find/replace block under several register
// settings. Directed strings cover the corner cases, then random phases
// build strings from pattern pieces. Both stream sides idle at random, and
// one long output stall backs the block up. Checking is done by the
// checker instance.
// ----------------------------------------------------------------------------
module stream_find_replace_tb
    import sfr_pkg::*;
;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_CHARS   = 26;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [63:0]           i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [23:0]           o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    int                    mismatches;
    int                    pending;
    bit                    steady    = 1'b0;
    bit                    stall_req = 1'b0;
    logic [63:0]           cur_pat   = '0;
    logic [3:0]            cur_plen  = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    stream_find_replace DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    stream_find_replace_checker u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    // offer one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] ch, input logic fin);
        while (!steady && $urandom_range(99) < 38) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_str(input string s, input logic close);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], close && (i == s.len() - 1));
        end
    endtask

    // mostly pattern pieces so that partial matches and fallbacks are common
    task automatic send_text(input int len);
        logic [7:0] text [$];
        int         plen;
        int         kind;
        int         cut;
        plen = (cur_plen > 8) ? 8 : cur_plen;
        while (text.size() < len) begin
            kind = $urandom_range(99);
            if (kind < 30 && plen > 0) begin
                for (int i = 0; i < plen; i++) begin
                    text.push_back(cur_pat[8*i +: 8]);
                end
            end else if (kind < 55 && plen > 1) begin
                cut = $urandom_range(plen - 1, 1);
                for (int i = 0; i < cut; i++) begin
                    text.push_back(cur_pat[8*i +: 8]);
                end
            end else if (kind < 80) begin
                text.push_back(cur_pat[8*$urandom_range(7) +: 8]);
            end else if (kind < 95) begin
                text.push_back(8'($urandom_range(255, 1)));
            end else begin
                text.push_back(8'h00);
            end
        end
        for (int i = 0; i < len; i++) begin
            send_char(text[i], i == len - 1);
        end
    endtask

    // drop valid, wait for every expected result, then let the block go quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen,
                             input logic [CAP_W-1:0] cap);
        settle();
        set_reg(CFG_PATTERN, pat);
        set_reg(CFG_PAT_LEN, {60'd0, plen});
        set_reg(CFG_REPLACEMENT, rep);
        set_reg(CFG_REP_LEN, {60'd0, rlen});
        set_reg(CFG_CAPACITY, {51'd0, cap});
        i_cfg_we <= 1'b0;
        cur_pat  = pat;
        cur_plen = plen;
    endtask

    // output side: random backpressure, plus one long hold-off on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= steady || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        logic [7:0]  ch_a;
        logic [7:0]  ch_b;
        logic [63:0] pat;
        logic [63:0] rep;
        int          plen_v;
        int          rlen_v;
        int          cap_v;
        int          r;
        int          len;
        int          n;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings pass text through, zero byte included
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);

        // overlapping candidates exercise the border fallback
        configure(pack_text("abab"), 4'd4, pack_text("XYZWVUTS"), 4'd8, 13'd4096);
        send_str("aabababc", 1'b1);

        // oversized lengths saturate, zero capacity emits nothing
        configure(pack_text("aaaaaaaa"), 4'd15, pack_text("12345678"), 4'd15, 13'd0);
        send_str("aab", 1'b1);

        // deletion with a capacity that cuts the string short
        configure(pack_text("a"), 4'd1, 64'd0, 4'd0, 13'd3);
        send_str("babbb", 1'b1);

        // shorten the pattern while bytes are held
        configure(pack_text("aaaa"), 4'd4, pack_text("RS"), 4'd2, 13'd8191);
        send_str("aaa", 1'b0);
        settle();
        set_reg(CFG_PAT_LEN, 64'd2);
        i_cfg_we <= 1'b0;
        send_str("b", 1'b1);

        // switch to pass-through while bytes are held
        configure(pack_text("abcd"), 4'd4, pack_text("RS"), 4'd2, 13'd8191);
        send_str("ab", 1'b0);
        settle();
        set_reg(CFG_PAT_LEN, 64'd0);
        i_cfg_we <= 1'b0;
        send_str("c", 1'b1);

        // every match expands eight-fold while the output is held off
        configure(pack_text("a"), 4'd1, pack_text("ABCDEFGH"), 4'd8, 13'd4096);
        steady    = 1'b1;
        stall_req = 1'b1;
        send_str("aaaaaaaaaaaaaaaaaaaab", 1'b1);
        steady = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            ch_a = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
            ch_b = 8'($urandom_range(255));
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(99) < 75) begin
                    pat[8*i +: 8] = $urandom_range(1) ? ch_a : ch_b;
                end else begin
                    pat[8*i +: 8] = 8'($urandom_range(255));
                end
            end
            plen_v = ($urandom_range(99) < 10) ? $urandom_range(15, 9) : $urandom_range(8, 0);
            rlen_v = ($urandom_range(99) < 10) ? $urandom_range(15, 9) : $urandom_range(8, 0);
            rep    = {$urandom, $urandom};
            r      = $urandom_range(99);
            if (r < 45) begin
                cap_v = $urandom_range(40, 0);
            end else if (r < 55) begin
                cap_v = $urandom_range(8191, 4097);
            end else if (r < 65) begin
                cap_v = 4096;
            end else begin
                cap_v = $urandom_range(4096, 41);
            end
            configure(pat, plen_v[3:0], rep, rlen_v[3:0], cap_v[CAP_W-1:0]);
            steady = (p == 2);
            n = 0;
            while (n < PHASE_CHARS) begin
                len = $urandom_range(20, 1);
                send_text(len);
                n += len;
            end
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0) begin
            $display("stream_find_replace regression: pass");
        end else begin
            $display("stream_find_replace regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("stream_find_replace regression: fail");
        $finish;
    end

endmodule
